>>> rtl/slcfp_pkg.sv
// Shared types, constants and the CRC-16 step for the sync/length/CRC frame parser.
// No dependencies; imported by the top level and the checker.
package slcfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 5;
  localparam int LENGTH_W = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h39;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h93;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CMD,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_REPLAY
  } phase_t;

  // Modbus CRC-16, reflected, one byte
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/slcfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sync_length_crc_frame_parser.sv
// Sync / length / CRC-16 (Modbus) frame parser, top level.
// Depends on slcfp_pkg and slcfp_ram (payload store).
//
// Takes one received byte per cycle while parsing: two sync bytes, a command byte, a
// big-endian 16-bit length, the payload and a CRC (high byte first). After a frame whose
// CRC matches, input stalls while the payload is replayed from the store, one read at a
// time (registered read of the store feeding the output register); an empty frame
// gives one result marked empty. Bad CRC and over-long frames are dropped silently.
module sync_length_crc_frame_parser
  import slcfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // byte input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    frame_command,
  output logic [BYTE_W-1:0]    data_byte,
  output logic [INDEX_W-1:0]   byte_index,
  output logic [LENGTH_W-1:0]  payload_length,
  output logic                 empty_payload,
  output logic                 last,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  phase_t phase, phase_next;

  logic [BYTE_W-1:0] sync_first, sync_second;
  logic [BYTE_W-1:0] cmd, len_hi, crc_hi;
  logic [CNT_W-1:0]  exp_len, rx_count, rd_ptr, rd_idx;
  logic [15:0]       crc;
  logic              rd_pending, rd_last;

  logic              slot_free, too_long, crc_good, ptr_at_end;
  logic              ram_we, rd_issue, load_empty;
  logic [CNT_W-1:0]  count_inc;
  logic [BYTE_W-1:0] ram_rdata;

  assign cfg_ready  = 1'b1;
  assign slot_free  = !out_valid || out_ready;
  assign too_long   = (len_hi != '0) || (rx_byte > BYTE_W'(MAX_PAYLOAD));
  assign crc_good   = ({crc_hi, rx_byte} == crc);
  assign count_inc  = rx_count + CNT_W'(1);
  assign ptr_at_end = ((rd_ptr + CNT_W'(1)) == rx_count);

  // next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SYNC1: begin
        if (in_valid && rx_byte == sync_first) phase_next = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (in_valid) phase_next = (rx_byte == sync_second) ? PH_CMD : PH_SYNC1;
      end
      PH_CMD: begin
        if (in_valid) phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (in_valid) phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (in_valid) begin
          priority if (too_long)          phase_next = PH_SYNC1;
          else if (rx_byte == '0)         phase_next = PH_CRC_HI;
          else                            phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (in_valid && count_inc >= exp_len) phase_next = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        if (in_valid) phase_next = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if (in_valid) phase_next = crc_good ? PH_REPLAY : PH_SYNC1;
      end
      PH_REPLAY: begin
        if (slot_free && !rd_pending && (rx_count == '0 || ptr_at_end)) begin
          phase_next = PH_SYNC1;
        end
      end
      default: phase_next = PH_SYNC1;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready   = 1'b1;
    ram_we     = 1'b0;
    rd_issue   = 1'b0;
    load_empty = 1'b0;
    unique case (phase)
      PH_DATA: begin
        ram_we = in_valid;
      end
      PH_REPLAY: begin
        in_ready = 1'b0;
        if (slot_free && !rd_pending) begin
          load_empty = (rx_count == '0);
          rd_issue   = (rx_count != '0);
        end
      end
      default: begin
        in_ready = 1'b1;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC1;
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      rd_pending  <= 1'b0;
      out_valid   <= 1'b0;
      rx_count    <= '0;
      crc         <= CRC_INIT;
    end else begin
      phase      <= phase_next;
      rd_pending <= rd_issue;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SYNC_FIRST:  sync_first  <= cfg_data;
          REG_SYNC_SECOND: sync_second <= cfg_data;
        endcase
      end
      if (load_empty || rd_pending) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        if (phase == PH_SYNC1 && rx_byte == sync_first) begin
          rx_count <= '0;
          crc      <= CRC_INIT;
        end else if (phase == PH_DATA) begin
          rx_count <= count_inc;
          crc      <= crc16_update(crc, rx_byte);
        end
      end
    end
  end

  // frame fields and replay pointer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      unique case (phase)
        PH_CMD:    cmd     <= rx_byte;
        PH_LEN_HI: len_hi  <= rx_byte;
        PH_LEN_LO: exp_len <= CNT_W'(rx_byte);
        PH_CRC_HI: crc_hi  <= rx_byte;
        PH_CRC_LO: rd_ptr  <= '0;
        default: ;
      endcase
    end
    if (rd_issue) begin
      rd_ptr  <= rd_ptr + CNT_W'(1);
      rd_idx  <= rd_ptr;
      rd_last <= ptr_at_end;
    end
  end

  // output register, loaded from the store read or with the empty-frame result
  always_ff @(posedge clk) begin
    if (load_empty) begin
      frame_command  <= cmd;
      data_byte      <= '0;
      byte_index     <= '0;
      payload_length <= '0;
      empty_payload  <= 1'b1;
      last           <= 1'b1;
    end else if (rd_pending) begin
      frame_command  <= cmd;
      data_byte      <= ram_rdata;
      byte_index     <= INDEX_W'(rd_idx);
      payload_length <= LENGTH_W'(rx_count);
      empty_payload  <= 1'b0;
      last           <= rd_last;
    end
  end

  slcfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rx_count[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (rd_issue),
    .raddr (rd_ptr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

endmodule

>>> rtl/slcfp_checker.sv
// Port-level checks for the frame parser, bound to the top level.
// Depends on slcfp_pkg and sync_length_crc_frame_parser.
module slcfp_checker
  import slcfp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [BYTE_W-1:0]    rx_byte,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [BYTE_W-1:0]    frame_command,
  input logic [BYTE_W-1:0]    data_byte,
  input logic [INDEX_W-1:0]   byte_index,
  input logic [LENGTH_W-1:0]  payload_length,
  input logic                 empty_payload,
  input logic                 last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_command) && $stable(data_byte)
      && $stable(byte_index) && $stable(last))
    else $error("result changed while stalled");

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(rx_byte))
    else $error("input item changed while stalled");

  // empty frame result is a single zeroed last item
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_payload |-> last && data_byte == '0 && byte_index == '0
      && payload_length == '0)
    else $error("malformed empty-frame result");

  // last payload byte sits at length minus one
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_payload && last |->
      byte_index == INDEX_W'(payload_length - LENGTH_W'(1)))
    else $error("last marker on wrong byte index");

endmodule

bind sync_length_crc_frame_parser slcfp_checker u_slcfp_checker (.*);
